>>> design/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types and constants of the timed crossfade blend core.
// ----------------------------------------------------------------------------
package tcb_pkg;

	localparam int FXP_RES    = 14;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam int S_DATA_W   = 112;
	localparam int M_DATA_W   = 48;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_START_INDEX   = 3'd0,
		REG_CLAIM_COUNT   = 3'd1,
		REG_TAG_LENGTH    = 3'd2,
		REG_FADE_DURATION = 3'd3,
		REG_LAYER_ALPHA   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [32:0] diff;
		logic signed [31:0] bg;
		logic [15:0]        index;
		logic               done;
	} tcb_item_t;

endpackage

>>> design/tcb_div.sv
// ----------------------------------------------------------------------------
// tcb_div
// Pipelined restoring divider: one quotient bit per stage, elapsed/duration.
// ----------------------------------------------------------------------------
module tcb_div #(
	parameter int FRAC_BITS = tcb_pkg::FXP_RES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [30:0]           divisor,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tcb_pkg::tcb_item_t    in_item,
	input  logic [30:0]           in_rem,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcb_pkg::tcb_item_t    out_item,
	output logic [FRAC_BITS-1:0]  out_quo
);
	import tcb_pkg::*;

	logic                 vld_sk  [FRAC_BITS];
	tcb_item_t            item_sk [FRAC_BITS];
	logic [30:0]          rem_sk  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_sk  [FRAC_BITS];
	logic [FRAC_BITS-1:0] rdy;

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
		logic                 prv_v;
		tcb_item_t            prv_item;
		logic [30:0]          prv_rem;
		logic [FRAC_BITS-1:0] prv_quo;
		logic                 nxt_rdy;
		logic [31:0]          dbl;
		logic                 ge;
		logic [30:0]          rem_nx;
		logic [FRAC_BITS-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign prv_v    = in_valid;
			assign prv_item = in_item;
			assign prv_rem  = in_rem;
			assign prv_quo  = '0;
		end else begin : g_next
			assign prv_v    = vld_sk[k-1];
			assign prv_item = item_sk[k-1];
			assign prv_rem  = rem_sk[k-1];
			assign prv_quo  = quo_sk[k-1];
		end

		if (k == FRAC_BITS - 1) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[k+1];
		end

		assign rdy[k] = !vld_sk[k] || nxt_rdy;
		assign dbl    = {prv_rem, 1'b0};
		assign ge     = dbl >= {1'b0, divisor};
		assign rem_nx = ge ? 31'(dbl - {1'b0, divisor}) : dbl[30:0];
		assign quo_nx = {prv_quo[FRAC_BITS-2:0], ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_sk[k] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prv_v) begin
				item_sk[k] <= prv_item;
				rem_sk[k]  <= rem_nx;
				quo_sk[k]  <= quo_nx;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_sk[FRAC_BITS-1];
	assign out_item  = item_sk[FRAC_BITS-1];
	assign out_quo   = quo_sk[FRAC_BITS-1];

endmodule

>>> design/tcb_blend.sv
// ----------------------------------------------------------------------------
// tcb_blend
// Alpha scaling, blend multiply, sum, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module tcb_blend #(
	parameter int FRAC_BITS = tcb_pkg::FXP_RES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [14:0]          alpha,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcb_pkg::tcb_item_t   in_item,
	input  logic [FRAC_BITS-1:0] in_quo,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          blended,
	output logic [15:0]          target_index,
	output logic                 fade_complete
);
	import tcb_pkg::*;

	localparam int FAD_W = FRAC_BITS + 1;
	localparam int APR_W = FAD_W + 15;
	localparam int SUM_W = ((FRAC_BITS + 32 > 48) ? FRAC_BITS + 32 : 48) + 1;
	localparam int ONE_M1 = (1 << FRAC_BITS) - 1;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(ONE_M1);

	logic rdy1, rdy2, rdy3, rdy4;

	// s1: fade factor times alpha
	logic                vld_s1;
	tcb_item_t           item_s1;
	logic [APR_W-1:0]    aprod_s1;
	logic [FAD_W-1:0]    fader;

	// s2: difference times scaled factor
	logic                vld_s2;
	logic signed [48:0]  wprod_s2;
	logic signed [31:0]  bg_s2;
	logic [15:0]         index_s2;
	logic                done_s2;
	logic [14:0]         fa;

	// s3: full-precision blend sum
	logic                vld_s3;
	logic signed [SUM_W-1:0] sum_s3;
	logic [15:0]         index_s3;
	logic                done_s3;

	// s4: output word
	logic                vld_s4;
	logic [31:0]         blended_s4;
	logic [15:0]         index_s4;
	logic                done_s4;
	logic signed [SUM_W-1:0] adj;
	logic signed [SUM_W-1:0] shq;
	logic [SUM_W-32:0]   hi;
	logic [31:0]         res;

	assign rdy4     = !vld_s4 || out_ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	assign fader = in_item.done ? FAD_W'(1 << FRAC_BITS) : {1'b0, in_quo};
	assign fa    = aprod_s1[FRAC_BITS +: 15];
	assign adj   = sum_s3 + (sum_s3[SUM_W-1] ? RND : SUM_W'(0));
	assign shq   = adj >>> FRAC_BITS;
	assign hi    = shq[SUM_W-1:31];
	assign res   = (&hi || ~|hi) ? shq[31:0] : (hi[SUM_W-32] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			item_s1  <= in_item;
			aprod_s1 <= APR_W'(fader) * APR_W'(alpha);
		end
		if (rdy2 && vld_s1) begin
			wprod_s2 <= item_s1.diff * $signed({1'b0, fa});
			bg_s2    <= item_s1.bg;
			index_s2 <= item_s1.index;
			done_s2  <= item_s1.done;
		end
		if (rdy3 && vld_s2) begin
			sum_s3   <= (SUM_W'(bg_s2) <<< FRAC_BITS) + SUM_W'(wprod_s2);
			index_s3 <= index_s2;
			done_s3  <= done_s2;
		end
		if (rdy4 && vld_s3) begin
			blended_s4 <= res;
			index_s4   <= index_s3;
			done_s4    <= done_s3;
		end
	end

	assign out_valid     = vld_s4;
	assign blended       = blended_s4;
	assign target_index  = index_s4;
	assign fade_complete = done_s4;

endmodule

>>> design/timed_crossfade_blend_core.sv
// ----------------------------------------------------------------------------
// timed_crossfade_blend_core
// Timed fixed-point crossfade of a layer element over a background element.
// ----------------------------------------------------------------------------
// Pipeline: one check stage, one divider stage per quotient bit, four blend stages.
// Throughput: one word per cycle while m_axis_tready holds; the divider stages set the depth.
// Reset clears all valid bits and config; layer_alpha resets to one.
module timed_crossfade_blend_core #(
	parameter int FRAC_BITS = tcb_pkg::FXP_RES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// elapsed_ms[30:0], background[62:31], foreground[94:63], element_offset[110:95]
	input  logic [tcb_pkg::S_DATA_W-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// blended[31:0], target_index[47:32]
	output logic [tcb_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// fade_complete[0]
	output logic [0:0]                     m_axis_tuser
);
	import tcb_pkg::*;

	localparam int ALPHA_ONE = (1 << FRAC_BITS) & 32'h7FFF;

	logic [15:0] start_index_q;
	logic [15:0] claim_count_q;
	logic [15:0] tag_length_q;
	logic [30:0] fade_duration_q;
	logic [14:0] layer_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_index_q   <= '0;
			claim_count_q   <= '0;
			tag_length_q    <= '0;
			fade_duration_q <= '0;
			layer_alpha_q   <= 15'(ALPHA_ONE);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_START_INDEX:   start_index_q   <= cfg_wdata[15:0];
				REG_CLAIM_COUNT:   claim_count_q   <= cfg_wdata[15:0];
				REG_TAG_LENGTH:    tag_length_q    <= cfg_wdata[15:0];
				REG_FADE_DURATION: fade_duration_q <= cfg_wdata;
				REG_LAYER_ALPHA:   layer_alpha_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// front check stage
	logic [30:0]        elapsed;
	logic signed [31:0] bg;
	logic signed [31:0] fg;
	logic [15:0]        offset;
	logic [16:0]        mapped;
	logic               keep;
	tcb_item_t          item;

	assign elapsed = s_axis_tdata[30:0];
	assign bg      = s_axis_tdata[62:31];
	assign fg      = s_axis_tdata[94:63];
	assign offset  = s_axis_tdata[110:95];
	assign mapped  = {1'b0, start_index_q} + {1'b0, offset};
	assign keep    = (offset < claim_count_q) && (mapped < {1'b0, tag_length_q});

	always_comb begin
		item.diff  = 33'(fg) - 33'(bg);
		item.bg    = bg;
		item.index = mapped[15:0];
		item.done  = elapsed >= fade_duration_q;
	end

	logic        vld_s1;
	tcb_item_t   item_s1;
	logic [30:0] rem_s1;
	logic        div_ready;

	assign s_axis_tready = !vld_s1 || div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item;
			rem_s1  <= elapsed;
		end
	end

	logic                 div_valid;
	logic                 blend_ready;
	tcb_item_t            div_item;
	logic [FRAC_BITS-1:0] div_quo;

	tcb_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.divisor   (fade_duration_q),
		.in_valid  (vld_s1),
		.in_ready  (div_ready),
		.in_item   (item_s1),
		.in_rem    (rem_s1),
		.out_valid (div_valid),
		.out_ready (blend_ready),
		.out_item  (div_item),
		.out_quo   (div_quo)
	);

	logic [31:0] blended;
	logic [15:0] target_index;
	logic        fade_complete;

	tcb_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.alpha         (layer_alpha_q),
		.in_valid      (div_valid),
		.in_ready      (blend_ready),
		.in_item       (div_item),
		.in_quo        (div_quo),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.blended       (blended),
		.target_index  (target_index),
		.fade_complete (fade_complete)
	);

	assign m_axis_tdata = {target_index, blended};
	assign m_axis_tuser = fade_complete;

endmodule

>>> design/tcb_checker.sv
// ----------------------------------------------------------------------------
// tcb_checker
// Port-level checks of the crossfade core, bound to the top level.
// ----------------------------------------------------------------------------
module tcb_checker #(
	parameter int FRAC_BITS = tcb_pkg::FXP_RES
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [tcb_pkg::S_DATA_W-1:0]   s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tcb_pkg::M_DATA_W-1:0]   m_axis_tdata,
	input logic [0:0]                     m_axis_tuser
);
	import tcb_pkg::*;

	localparam int MIN_LAT = FRAC_BITS + 5;
	localparam int CNT_W   = $clog2(MIN_LAT + 1);

	logic [CNT_W-1:0] up_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_cnt_q <= '0;
		end else if (up_cnt_q < CNT_W'(MIN_LAT)) begin
			up_cnt_q <= up_cnt_q + 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input word changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side is ready");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		up_cnt_q < CNT_W'(MIN_LAT) |-> !m_axis_tvalid)
		else $error("output word earlier than pipeline latency");

endmodule

bind timed_crossfade_blend_core tcb_checker #(.FRAC_BITS(FRAC_BITS)) u_tcb_checker (.*);

>>> tb/sv/crossfade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfade_checker
// Watches the config port and both stream channels of the crossfade core.
// Every accepted input word is run through a local blend predictor that keeps
// its own register copy. Each output word is compared in order against the
// oldest predicted blend. The mismatch count and the number of blends still
// outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module crossfade_checker #(
	parameter int FRAC_BITS = tcb_pkg::FXP_RES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// elapsed_ms[30:0], background[62:31], foreground[94:63], element_offset[110:95]
	input  logic [tcb_pkg::S_DATA_W-1:0]   s_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// blended[31:0], target_index[47:32]
	input  logic [tcb_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// fade_complete[0]
	input  logic [0:0]                     m_axis_tuser,
	output int                             mismatches,
	output int                             pending_blends
);
	import tcb_pkg::*;

	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] blended;
		logic [15:0]        target_index;
		logic               fade_complete;
	} blend_result_t;

	logic [15:0]   start_index;
	logic [15:0]   claim_count;
	logic [15:0]   tag_length;
	logic [30:0]   fade_duration;
	logic [14:0]   layer_alpha;
	blend_result_t expected_blends[$];

	function automatic bit predict_blend(input logic [S_DATA_W-1:0] word,
			output blend_result_t res);
		logic [30:0]        elapsed;
		logic signed [31:0] bg;
		logic signed [31:0] fg;
		logic [15:0]        offset;
		logic [16:0]        mapped;
		logic [63:0]        fader;
		longint             acc;
		elapsed = word[30:0];
		bg      = word[62:31];
		fg      = word[94:63];
		offset  = word[110:95];
		res     = '{default: 0};
		mapped  = {1'b0, start_index} + {1'b0, offset};
		if (offset >= claim_count || mapped >= {1'b0, tag_length})
			return 0;
		res.fade_complete = (elapsed >= fade_duration);
		if (res.fade_complete)
			fader = 64'(ONE);
		else
			fader = ({33'd0, elapsed} << FRAC_BITS) / {33'd0, fade_duration};
		fader = (fader * {49'd0, layer_alpha}) >> FRAC_BITS;
		acc = longint'(bg) * (ONE - longint'(fader)) + longint'(fg) * longint'(fader);
		acc = acc / ONE;
		if (acc > MAX32)
			acc = MAX32;
		if (acc < MIN32)
			acc = MIN32;
		res.blended      = acc[31:0];
		res.target_index = mapped[15:0];
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		blend_result_t want;
		bit            hit;
		if (!arst_n) begin
			start_index   = '0;
			claim_count   = '0;
			tag_length    = '0;
			fade_duration = '0;
			layer_alpha   = 15'(ONE);
			expected_blends.delete();
			mismatches     = 0;
			pending_blends = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_blends.size() == 0) begin
					$error("unexpected word: blended %0d target_index %0d",
						$signed(m_axis_tdata[31:0]), m_axis_tdata[47:32]);
					mismatches++;
				end else begin
					want = expected_blends.pop_front();
					if ($signed(m_axis_tdata[31:0]) != want.blended) begin
						$error("blended: expected %0d, actual %0d",
							want.blended, $signed(m_axis_tdata[31:0]));
						mismatches++;
					end
					if (m_axis_tdata[47:32] != want.target_index) begin
						$error("target_index: expected %0d, actual %0d",
							want.target_index, m_axis_tdata[47:32]);
						mismatches++;
					end
					if (m_axis_tuser[0] != want.fade_complete) begin
						$error("fade_complete: expected %0d, actual %0d",
							want.fade_complete, m_axis_tuser[0]);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				hit = predict_blend(s_axis_tdata, want);
				if (hit)
					expected_blends = {expected_blends, want};
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_START_INDEX:   start_index   = cfg_wdata[15:0];
					REG_CLAIM_COUNT:   claim_count   = cfg_wdata[15:0];
					REG_TAG_LENGTH:    tag_length    = cfg_wdata[15:0];
					REG_FADE_DURATION: fade_duration = cfg_wdata[30:0];
					REG_LAYER_ALPHA:   layer_alpha   = cfg_wdata[14:0];
					default: ;
				endcase
			end
			pending_blends = expected_blends.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the timed crossfade blend core. A directed set
// covers the field extremes, out of layer and out of target elements, zero
// duration and alpha above one with saturation. Random blocks follow under
// random register settings and three idle mixes, with one long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import tcb_pkg::*;

	localparam int LIMIT        = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = FXP_RES + 5 + 8;
	localparam int BLOCK_ITEMS  = 75;
	localparam int BLOCKS       = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	int                    mismatches;
	int                    pending_blends;

	int          tx_idle;
	int          rx_idle;
	bit          hold_req;
	int          hold_left;
	logic [15:0] cur_claim;
	logic [30:0] cur_dur;

	timed_crossfade_blend_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	crossfade_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.mismatches     (mismatches),
		.pending_blends (pending_blends)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin : receiver
		m_axis_tready = 1'b0;
		hold_left     = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall = 0;
			else
				stall++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_word(input logic [30:0] elapsed, input logic [31:0] bg,
			input logic [31:0] fg, input logic [15:0] offset);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, offset, fg, bg, elapsed};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle_pipeline();
		s_axis_tvalid <= 1'b0;
		while (pending_blends != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input cfg_reg_t addr, input logic [30:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic write_config(input logic [15:0] st, input logic [15:0] cl,
			input logic [15:0] tg, input logic [30:0] du, input logic [14:0] al);
		settle_pipeline();
		reg_write(REG_START_INDEX, 31'(st));
		reg_write(REG_CLAIM_COUNT, 31'(cl));
		reg_write(REG_TAG_LENGTH, 31'(tg));
		reg_write(REG_FADE_DURATION, du);
		reg_write(REG_LAYER_ALPHA, 31'(al));
		cfg_we    <= 1'b0;
		cur_claim = cl;
		cur_dur   = du;
		@(negedge clk);
	endtask

	task automatic random_config();
		logic [15:0] st;
		logic [15:0] cl;
		logic [15:0] tg;
		logic [30:0] du;
		logic [14:0] al;
		int          r;
		r  = $urandom_range(0, 9);
		st = (r < 7) ? 16'($urandom_range(0, 2047)) :
			(r < 9) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
		cl = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(1, 65535)) : 16'hFFFF;
		tg = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(st, 65535));
		r  = $urandom_range(0, 9);
		if (r == 0)
			du = '0;
		else if (r < 5)
			du = 31'($urandom_range(1, 5000));
		else if (r < 8)
			du = 31'($urandom_range(1, 1 << 20));
		else
			du = 31'($urandom);
		r  = $urandom_range(0, 9);
		al = (r < 6) ? 15'd16384 : (r < 8) ? 15'($urandom_range(0, 32767)) :
			(r == 8) ? 15'd0 : 15'h7FFF;
		write_config(st, cl, tg, du, al);
	endtask

	task automatic random_item();
		logic [30:0] el;
		logic [31:0] bg;
		logic [31:0] fg;
		logic [15:0] off;
		logic [63:0] span;
		logic [63:0] wide;
		int          r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			el = 31'($urandom);
		end else if (r == 2) begin
			el = cur_dur;
		end else begin
			span = {33'd0, cur_dur} + ({33'd0, cur_dur} >> 2) + 64'd1;
			wide = {$urandom, $urandom} % span;
			el   = (wide > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : wide[30:0];
		end
		r  = $urandom_range(0, 19);
		bg = (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 : $urandom;
		r  = $urandom_range(0, 19);
		fg = (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 : $urandom;
		if ($urandom_range(0, 99) < 85)
			off = 16'($urandom_range(0, cur_claim - 1));
		else
			off = 16'($urandom_range(0, 65535));
		send_word(el, bg, fg, off);
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		hold_req      = 1'b0;
		tx_idle       = 21;
		rx_idle       = 49;
		cur_claim     = '0;
		cur_dur       = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: empty layer, nothing comes out
		send_word(31'd0, 32'd100, 32'd200, 16'd0);
		send_word(31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);

		write_config(16'd0, 16'hFFFF, 16'hFFFF, 31'd1000, 15'd16384);
		send_word(31'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
		send_word(31'd500, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		send_word(31'd999, 32'd1000, -32'sd1000, 16'd2);
		send_word(31'd1000, 32'd5, 32'd9, 16'd3);
		send_word(31'h7FFF_FFFF, -32'sd7, 32'd7, 16'd4);
		send_word(31'd1, -32'sd1, 32'd1, 16'd5);
		send_word(31'd333, -32'sd3, 32'd0, 16'hFFFE);
		send_word(31'd500, 32'd1, 32'd2, 16'hFFFF);
		send_word(31'd0, 32'd0, 32'd0, 16'd0);

		// mapped index at and past the end of the 16-bit target: nothing comes out
		write_config(16'hFFFF, 16'd2, 16'hFFFF, 31'd1000, 15'd16384);
		send_word(31'd500, 32'd10, 32'd20, 16'd0);
		send_word(31'd500, 32'd10, 32'd20, 16'd1);

		write_config(16'd65000, 16'd600, 16'hFFFF, 31'h7FFF_FFFF, 15'd16384);
		send_word(31'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd534);
		send_word(31'd12345, -32'sd100000, 32'd100000, 16'd535);
		send_word(31'h4000_0000, 32'h1234_5678, 32'hEDCB_A987, 16'd0);

		// zero duration with alpha above one saturates
		write_config(16'd0, 16'hFFFF, 16'hFFFF, 31'd0, 15'h7FFF);
		send_word(31'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd7);
		send_word(31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd8);
		send_word(31'd5, 32'd1000, -32'sd1000, 16'd9);

		write_config(16'd100, 16'hFFFF, 16'hFFFF, 31'd0, 15'd0);
		send_word(31'd0, 32'd123, 32'd456, 16'd65434);
		send_word(31'd77, -32'sd5, 32'd5, 16'd0);

		write_config(16'd0, 16'd1, 16'd0, 31'd100, 15'd16384);
		send_word(31'd50, 32'd1, 32'd2, 16'd0);

		write_config(16'd0, 16'hFFFF, 16'hFFFF, 31'd1000, 15'd20000);
		send_word(31'd900, 32'h7FFF_FFFF, 32'h8000_0000, 16'd10);
		send_word(31'd999, 32'h8000_0000, 32'h7FFF_FFFF, 16'd11);

		for (int b = 0; b < BLOCKS; b++) begin
			random_config();
			case (b / 2)
				0: begin
					tx_idle = 21;
					rx_idle = 49;
				end
				1: begin
					tx_idle = 49;
					rx_idle = 21;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			if (b == 4)
				hold_req = 1'b1;
			repeat (BLOCK_ITEMS) random_item();
		end

		settle_pipeline();
		if (mismatches == 0 && pending_blends == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> timed_crossfade_blend_core.f
design/tcb_pkg.sv
design/tcb_div.sv
design/tcb_blend.sv
design/timed_crossfade_blend_core.sv
design/tcb_checker.sv
tb/sv/crossfade_checker.sv
tb/sv/testbench.sv
